[rtl/msc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI switcher control parser package
// Shared phase codes, MIDI command constants and the result record.
// ----------------------------------------------------------------------------
package msc_pkg;

    typedef logic [2:0] t_phase;

    // Parser phases; unused codes behave as PH_CMD
    localparam t_phase PH_CMD   = 3'd0;
    localparam t_phase PH_SYSEX = 3'd1;
    localparam t_phase PH_CTRL  = 3'd2;
    localparam t_phase PH_VAL   = 3'd3;
    localparam t_phase PH_PROG  = 3'd4;

    // Command bytes
    localparam logic [7:0] CMD_SYSEX_START = 8'hF0;
    localparam logic [7:0] CMD_SYSEX_END   = 8'hF7;
    localparam logic [7:0] CMD_CTRL_CHANGE = 8'hB0;
    localparam logic [7:0] CMD_PROG_CHANGE = 8'hC0;

    // Controller numbers
    localparam logic [7:0] CC_BUS_SELECT = 8'h00;
    localparam logic [7:0] CC_BANK_LSB   = 8'h20;
    localparam logic [7:0] CC_FADER      = 8'h12;

    localparam logic [7:0] FADER_TOP = 8'd127;

    // Bus selector values
    localparam logic [7:0] BUS_A = 8'd0;
    localparam logic [7:0] BUS_B = 8'd1;

    // Event kinds
    localparam logic EV_SWAP = 1'b0;
    localparam logic EV_PROG = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] a_index;
        logic [8:0] b_number;
    } t_result;

endpackage : msc_pkg
`default_nettype wire

[rtl/msc_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI switcher parser core
// Parser state and the combinational update for one registered byte.
// ----------------------------------------------------------------------------
module msc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output msc_pkg::t_result     o_result
);
    import msc_pkg::*;

    t_phase     r_phase,      n_phase;
    logic [7:0] r_ctrl_num,   n_ctrl_num;
    logic [7:0] r_bus,        n_bus;
    logic [8:0] r_program_a,  n_program_a;
    logic [8:0] r_preset_b,   n_preset_b;
    logic [7:0] r_fader,      n_fader;
    logic [7:0] r_fade_start, n_fade_start;

    logic       swap;
    logic [8:0] a_minus_one;

    // Fader reaching an end stop away from where the fade began
    assign swap = (i_byte != r_fade_start)
                && (((r_fader != 8'd0) && (i_byte == 8'd0))
                 || ((i_byte == FADER_TOP) && (r_fader < FADER_TOP)));

    always_comb begin
        n_phase      = r_phase;
        n_ctrl_num   = r_ctrl_num;
        n_bus        = r_bus;
        n_program_a  = r_program_a;
        n_preset_b   = r_preset_b;
        n_fader      = r_fader;
        n_fade_start = r_fade_start;
        o_result.valid = 1'b0;
        o_result.kind  = EV_SWAP;

        case (r_phase)
            PH_SYSEX: begin
                if (i_byte == CMD_SYSEX_END) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CTRL: begin
                n_ctrl_num = i_byte;
                n_phase    = PH_VAL;
            end
            PH_VAL: begin
                n_phase = PH_CMD;
                if (r_ctrl_num == CC_BUS_SELECT) begin
                    n_bus = i_byte;
                end else if (r_ctrl_num == CC_FADER) begin
                    if (swap) begin
                        n_program_a    = r_preset_b;
                        n_preset_b     = r_program_a;
                        n_fade_start   = i_byte;
                        o_result.valid = 1'b1;
                        o_result.kind  = EV_SWAP;
                    end
                    n_fader = i_byte;
                end
                // CC_BANK_LSB and other controllers: nothing
            end
            PH_PROG: begin
                n_phase = PH_CMD;
                if (r_bus == BUS_A) begin
                    n_program_a    = {1'b0, i_byte} + 9'd1;
                    o_result.valid = 1'b1;
                    o_result.kind  = EV_PROG;
                end else if (r_bus == BUS_B) begin
                    n_preset_b = {1'b0, i_byte} + 9'd1;
                end
            end
            default: begin
                n_phase = PH_CMD;
                if (i_byte == CMD_SYSEX_START) begin
                    n_phase = PH_SYSEX;
                end else if (i_byte == CMD_CTRL_CHANGE) begin
                    n_phase = PH_CTRL;
                end else if (i_byte == CMD_PROG_CHANGE) begin
                    n_phase = PH_PROG;
                end
            end
        endcase

        // Event fields show the state after the update
        a_minus_one       = n_program_a - 9'd1;
        o_result.a_index  = a_minus_one[7:0];
        o_result.b_number = n_preset_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CMD;
            r_ctrl_num   <= 8'd0;
            r_bus        <= 8'd0;
            r_program_a  <= 9'd1;
            r_preset_b   <= 9'd2;
            r_fader      <= 8'd0;
            r_fade_start <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_ctrl_num   <= n_ctrl_num;
            r_bus        <= n_bus;
            r_program_a  <= n_program_a;
            r_preset_b   <= n_preset_b;
            r_fader      <= n_fader;
            r_fade_start <= n_fade_start;
        end
    end

    // A swap leaves the fade start equal to the new fader level
    a_swap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.valid && (o_result.kind == EV_SWAP))
        |=> (r_fade_start == r_fader))
        else $error("fade start not updated on swap");

    // Program change events only from the program phase with bus A selected
    a_prog_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.kind == EV_PROG))
        |-> ((r_phase == PH_PROG) && (r_bus == BUS_A)))
        else $error("program event outside program phase");

    // Program numbers are never zero
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_program_a != 9'd0) && (r_preset_b != 9'd0))
        else $error("program number zero");

    // Swap exchanges the two programs
    a_swap_xchg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.valid && (o_result.kind == EV_SWAP))
        |=> ((r_program_a == $past(r_preset_b)) && (r_preset_b == $past(r_program_a))))
        else $error("swap did not exchange programs");

endmodule : msc_core
`default_nettype wire

[rtl/midi_switcher_control_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI switcher control parser
// Parses a MIDI byte stream and reports program swaps and program A changes.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per item, with no running status: any byte in a data
// position is data. Each byte is captured in an input register, handled by
// the parser core, and any event lands in an output register. Throughput
// is one item per cycle while the output side keeps up. An event is offered
// from the output register once the core has handled its byte. While an
// event waits in the output register the core holds; the input register
// takes one more byte and then ready drops until the event is taken. Bytes
// that raise no event (system exclusive, bus select, ignored controllers,
// bus B programs) still pass through the input stage and the core but
// produce no result. An event carries its kind (fader swap or program A
// change), program A less one and preset B, both as they stand after the
// update.
// ----------------------------------------------------------------------------
module midi_switcher_control_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte_value,
    // event output
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_event_kind,
    output logic [7:0]      o_program_a_index,
    output logic [8:0]      o_preset_b_number
);
    import msc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       r_out_kind;
    logic [7:0] r_out_a_index;
    logic [8:0] r_out_b_number;

    logic       out_free;
    logic       advance;
    t_result    result;

    // Output slot free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || advance;

    msc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_kind     <= result.kind;
            r_out_a_index  <= result.a_index;
            r_out_b_number <= result.b_number;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_kind      = r_out_kind;
    assign o_program_a_index = r_out_a_index;
    assign o_preset_b_number = r_out_b_number;

    // A stalled result is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !advance)
        else $error("result overwritten while stalled");

    // A held input byte stays put until the core consumes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost");

    // Input side free whenever the input register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("ready low with empty input stage");

endmodule : midi_switcher_control_parser
`default_nettype wire
